>>> hdl/interval_predecessor_index_search_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the interval predecessor index search
// Shared forms for concurrent checks, clocked on the rising edge and
// disabled while the active-low reset is asserted.
// ----------------------------------------------------------------------------
`ifndef INTERVAL_PREDECESSOR_INDEX_SEARCH_DEFINES_SVH
`define INTERVAL_PREDECESSOR_INDEX_SEARCH_DEFINES_SVH

// Same-cycle implication.
`define IPIS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipis: same-cycle check failed");

// Next-cycle implication.
`define IPIS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipis: next-cycle check failed");

`endif

>>> hdl/ipis_pkg.sv
// ----------------------------------------------------------------------------
// ipis_pkg
// Constants for the interval predecessor index search: field widths,
// parameter defaults and operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ipis_pkg;

  localparam int TableDepthDef = 1024;
  localparam int PosWidthDef   = 32;

  localparam int EntryW = 10;
  localparam int CountW = 11;
  localparam int IndexW = 10;

  localparam logic [CountW-1:0] CountReset = 11'd1;

  localparam logic OpWrite = 1'b0;
  localparam logic OpQuery = 1'b1;

endpackage

`default_nettype wire

>>> hdl/ipis_ram.sv
// ----------------------------------------------------------------------------
// ipis_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ipis_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> hdl/interval_predecessor_index_search.sv
// ----------------------------------------------------------------------------
// interval_predecessor_index_search
// Table of (input start, output start) pairs in two RAMs. A query reads the
// output start of one entry and binary-searches the input starts for the
// largest index whose start is at most that key.
//
//   channel   direction  handshake              payload
//   in        request    in_valid_i/in_stall_o  operation, entry, input/output start
//   out       result     out_valid_o/out_stall_i found_index, out_of_range
//   cfg       write      cfg_we_i               cfg_wdata_i (entry_count)
//
// A write request gives no result.
// A query holds the input from acceptance until its result is loaded: accept,
// one key read, up to ceil(log2(n)) probes of the input-start RAM for n entries
// in use, then the result load. Out of range or one entry in use: no probes.
// The probe loop through the RAM read port sets how long the input is held.
// Reset clears control state and sets entry_count to 1; the RAMs are not
// cleared. A stalled result holds the search in its last state until taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "interval_predecessor_index_search_defines.svh"

module interval_predecessor_index_search import ipis_pkg::*; #(
  parameter int TABLE_DEPTH = TableDepthDef,
  parameter int POS_WIDTH   = PosWidthDef
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,

  input  wire logic                 cfg_we_i,
  input  wire logic [CountW-1:0]    cfg_wdata_i,

  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 operation_i,
  input  wire logic [EntryW-1:0]    entry_i,
  input  wire logic [POS_WIDTH-1:0] input_start_i,
  input  wire logic [POS_WIDTH-1:0] output_start_i,

  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [IndexW-1:0]         found_index_o,
  output logic                      out_of_range_o
);

  localparam int AW = $clog2(TABLE_DEPTH);
  // wide enough for entry, count and depth, plus headroom for compares
  localparam int XW = ((AW > CountW) ? AW : CountW) + 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KEY,
    ST_PROBE,
    ST_DONE
  } state_e;

  state_e                state_q;
  logic [CountW-1:0]     count_q;
  logic [AW-1:0]         lo_q, hi_q, mid_q;
  logic [POS_WIDTH-1:0]  key_q;
  logic                  oor_q;
  logic                  out_valid_q;
  logic [IndexW-1:0]     found_q;
  logic                  out_oor_q;

  logic                  in_acc;
  logic                  out_free;
  logic [XW-1:0]         entry_ext, count_ext, depth_ext, count_eff, count_eff_m1, lo_ext;
  logic [AW-1:0]         entry_addr, hi_init;
  logic                  wr_en;
  logic [AW-1:0]         lo_d, hi_d, mid_d;
  logic [AW:0]           mid_sum;
  logic [POS_WIDTH-1:0]  in_rdata, out_rdata;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign entry_ext    = XW'(entry_i);
  assign entry_addr   = entry_ext[AW-1:0];
  assign count_ext    = XW'(count_q);
  assign depth_ext    = XW'(TABLE_DEPTH);
  assign count_eff    = (count_ext > depth_ext) ? depth_ext : count_ext;
  assign count_eff_m1 = count_eff - XW'(1);
  assign hi_init      = count_eff_m1[AW-1:0];
  assign lo_ext       = XW'(lo_q);

  // drop writes that land beyond the table
  assign wr_en = in_acc && (operation_i == OpWrite) && (entry_ext < depth_ext);

  // narrow the interval from the probe that just returned, then pick the next mid
  always_comb begin
    lo_d = lo_q;
    hi_d = hi_q;
    if (state_q == ST_PROBE) begin
      if (in_rdata > key_q) begin
        hi_d = mid_q - AW'(1);
      end else begin
        lo_d = mid_q;
      end
    end
    mid_sum = {1'b0, lo_d} + {1'b0, hi_d};
    mid_d   = mid_sum[AW:1] + AW'(1);
  end

  ipis_ram #(
    .Width (POS_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_in_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_addr),
    .wdata_i (input_start_i),
    .raddr_i (mid_d),
    .rdata_o (in_rdata)
  );

  ipis_ram #(
    .Width (POS_WIDTH),
    .Depth (TABLE_DEPTH)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (entry_addr),
    .wdata_i (output_start_i),
    .raddr_i (entry_addr),
    .rdata_o (out_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= CountReset;
      lo_q        <= '0;
      hi_q        <= '0;
      mid_q       <= '0;
      key_q       <= '0;
      oor_q       <= 1'b0;
      out_valid_q <= 1'b0;
      found_q     <= '0;
      out_oor_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
      // the done state reloads the output register itself
      if (out_valid_q && !out_stall_i && (state_q != ST_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc && (operation_i == OpQuery)) begin
            oor_q   <= (entry_ext >= count_eff);
            lo_q    <= '0;
            hi_q    <= hi_init;
            state_q <= ST_KEY;
          end
        end
        ST_KEY: begin
          key_q <= out_rdata;
          if (oor_q || (lo_q == hi_q)) begin
            state_q <= ST_DONE;
          end else begin
            mid_q   <= mid_d;
            state_q <= ST_PROBE;
          end
        end
        ST_PROBE: begin
          lo_q  <= lo_d;
          hi_q  <= hi_d;
          mid_q <= mid_d;
          if (lo_d == hi_d) begin
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          // hold until the output register frees up
          if (out_free) begin
            found_q     <= oor_q ? '0 : lo_ext[IndexW-1:0];
            out_oor_q   <= oor_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign found_index_o  = found_q;
  assign out_of_range_o = out_oor_q;

  `IPIS_ASSERT_NOW(a_probe_mid_inside, clk_i, rst_ni, state_q == ST_PROBE, (mid_q > lo_q) && (mid_q <= hi_q))
  `IPIS_ASSERT_NOW(a_oor_index_zero, clk_i, rst_ni, out_valid_o && out_of_range_o, found_index_o == '0)
  `IPIS_ASSERT_NOW(a_result_from_done, clk_i, rst_ni, $rose(out_valid_q), $past(state_q) == ST_DONE)
  `IPIS_ASSERT_NEXT(a_query_reads_key, clk_i, rst_ni, in_acc && (operation_i == OpQuery), state_q == ST_KEY)

endmodule

`default_nettype wire

>>> sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for interval_predecessor_index_search. A typed table of
// directed requests comes first. Then the full table is loaded with sorted
// starts and mixed writes and lookups run under several entry counts. Each
// lookup result is compared with its typed expectation or a local binary-search predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import ipis_pkg::*;

  localparam int Depth       = TableDepthDef;
  localparam int SettleWait  = 24;    // covers one full-depth lookup
  localparam int QuietLimit  = 5000;  // cycles with no handshake at all
  localparam int HoldCycles  = 400;
  localparam int PhaseItems  = 62;

  typedef enum logic {RowReq, RowCfg} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic              op;
    logic [EntryW-1:0] entry;
    logic [31:0]       in_s;
    logic [31:0]       out_s;
    logic [CountW-1:0] cnt;
    bit                typed;
    logic [IndexW-1:0] t_idx;
    logic              t_oor;
  } dir_row_t;

  typedef struct packed {
    logic [IndexW-1:0] idx;
    logic              oor;
  } lookup_t;

  // Fields that are not used by a row stay zero.
  dir_row_t dir_rows [24] = '{
    '{RowReq, OpWrite, 10'd0,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd0,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd1,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b1},
    '{RowReq, OpQuery, 10'd1023, 32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b1},
    '{RowReq, OpWrite, 10'd1,    32'd100,       32'd100,       11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpWrite, 10'd2,    32'd200,       32'd50,        11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpWrite, 10'd3,    32'hFFFF_FFFF, 32'hFFFF_FFFF, 11'd0, 1'b0, 10'd0, 1'b0},
    '{RowCfg, OpWrite, 10'd0,    32'd0,         32'd0,         11'd4, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd3,    32'd0,         32'd0,         11'd0, 1'b1, 10'd3, 1'b0},
    '{RowReq, OpQuery, 10'd0,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd2,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd1,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpWrite, 10'd0,    32'd10,        32'd5,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd0,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b0},
    '{RowCfg, OpWrite, 10'd0,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd0,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b1},
    '{RowReq, OpQuery, 10'd1023, 32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b1},
    '{RowCfg, OpWrite, 10'd0,    32'd0,         32'd0,         11'd3, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpWrite, 10'd1,    32'd300,       32'd300,       11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd2,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd1,    32'd0,         32'd0,         11'd0, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd3,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b1},
    '{RowCfg, OpWrite, 10'd0,    32'd0,         32'd0,         11'd1, 1'b0, 10'd0, 1'b0},
    '{RowReq, OpQuery, 10'd0,    32'd0,         32'd0,         11'd0, 1'b1, 10'd0, 1'b0}
  };

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              cfg_we_i       = 1'b0;
  logic [CountW-1:0] cfg_wdata_i    = '0;
  logic              in_valid_i     = 1'b0;
  logic              in_stall_o;
  logic              operation_i    = OpWrite;
  logic [EntryW-1:0] entry_i        = '0;
  logic [31:0]       input_start_i  = '0;
  logic [31:0]       output_start_i = '0;
  logic              out_valid_o;
  logic              out_stall_i    = 1'b0;
  logic [IndexW-1:0] found_index_o;
  logic              out_of_range_o;

  // Predictor state
  logic [31:0]       in_starts  [Depth];
  logic [31:0]       out_starts [Depth];
  logic [CountW-1:0] entries_in_use;
  lookup_t           expected_lookups [$];

  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int err_cnt  = 0;
  int n_writes = 0;
  int n_lookups = 0;
  int n_oor    = 0;
  int n_cfg    = 0;

  interval_predecessor_index_search dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .entry_i        (entry_i),
    .input_start_i  (input_start_i),
    .output_start_i (output_start_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .found_index_o  (found_index_o),
    .out_of_range_o (out_of_range_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic int unsigned active_count();
    return (entries_in_use > Depth) ? Depth : int'(entries_in_use);
  endfunction

  // Largest index below the active count whose input start is at most the key
  // taken from the queried entry.
  function automatic lookup_t search_predecessor(logic [EntryW-1:0] entry);
    int unsigned cnt;
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    logic [31:0] key;
    lookup_t     res;
    cnt = active_count();
    res = '0;
    if (entry >= cnt) begin
      res.oor = 1'b1;
    end else begin
      key = out_starts[entry];
      lo  = 0;
      hi  = cnt - 1;
      while (lo != hi) begin
        mid = (lo + hi) / 2 + 1;
        if (in_starts[mid] > key) hi = mid - 1;
        else lo = mid;
      end
      res.idx = lo[IndexW-1:0];
    end
    return res;
  endfunction

  // Pick a start that keeps the neighbors in order where they still are.
  function automatic logic [31:0] sorted_start(int e);
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned span;
    lo = (e == 0) ? 64'd0 : longint'(in_starts[e-1]);
    hi = (e == Depth - 1) ? 64'hFFFF_FFFF : longint'(in_starts[e+1]);
    if (lo > hi) return $urandom;
    span = hi - lo + 1;
    return 32'(lo + ({$urandom, $urandom} % span));
  endfunction

  // Keys land mostly on or next to a stored start.
  function automatic logic [31:0] pick_key();
    logic [31:0] base;
    base = in_starts[$urandom_range(0, Depth - 1)];
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return base + 32'($urandom_range(0, 2)) - 32'd1;
    endcase
  endfunction

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
  endtask

  task automatic set_count(logic [CountW-1:0] value);
    drain();
    repeat (SettleWait) @(posedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i       <= 1'b0;
    entries_in_use  = value;
    n_cfg++;
  endtask

  task automatic send_req(logic op, logic [EntryW-1:0] entry, logic [31:0] in_s,
                          logic [31:0] out_s, bit typed = 1'b0,
                          logic [IndexW-1:0] t_idx = '0, logic t_oor = 1'b0);
    lookup_t res;
    while (!calm && $urandom_range(0, 99) < 35) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    entry_i        <= entry;
    input_start_i  <= in_s;
    output_start_i <= out_s;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    // request taken at this edge
    if (op == OpWrite) begin
      in_starts[entry]  = in_s;
      out_starts[entry] = out_s;
      n_writes++;
    end else begin
      res = typed ? lookup_t'{t_idx, t_oor} : search_predecessor(entry);
      expected_lookups.push_back(res);
      n_lookups++;
      if (res.oor) n_oor++;
    end
  endtask

  task automatic run_mixed(int items, int wr_pct);
    int               e;
    int unsigned      cnt;
    logic [EntryW-1:0] q;
    for (int i = 0; i < items; i++) begin
      if ($urandom_range(0, 99) < wr_pct) begin
        e = $urandom_range(0, Depth - 1);
        send_req(OpWrite, e[EntryW-1:0],
                 ($urandom_range(0, 9) == 0) ? $urandom : sorted_start(e), pick_key());
      end else begin
        cnt = active_count();
        if (cnt == 0 || $urandom_range(0, 4) == 0) q = EntryW'($urandom_range(0, Depth - 1));
        else q = EntryW'($urandom_range(0, cnt - 1));
        send_req(OpQuery, q, $urandom, $urandom);
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off on request.
  initial begin : result_stall
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req     = 1'b0;
        hold_left    = HoldCycles;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= !calm && ($urandom_range(0, 99) < 35);
      end
    end
  end

  always @(posedge clk_i) begin
    lookup_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_lookups.size() == 0) begin
        $display("%0t: unexpected result found_index=%0d out_of_range=%0b",
                 $realtime, found_index_o, out_of_range_o);
        err_cnt++;
      end else begin
        want = expected_lookups.pop_front();
        if (found_index_o !== want.idx) begin
          $display("%0t: found_index expected %0d actual %0d",
                   $realtime, want.idx, found_index_o);
          err_cnt++;
        end
        if (out_of_range_o !== want.oor) begin
          $display("%0t: out_of_range expected %0b actual %0b",
                   $realtime, want.oor, out_of_range_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $realtime, QuietLimit);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [CountW-1:0] phase_counts [12];
    logic [31:0]       fill_start;
    entries_in_use = CountReset;
    phase_counts   = '{11'd2047, 11'd1024, 11'd1, 11'd0, 11'd2, 11'd1023,
                       11'd1025, 11'd0, 11'd3, 11'd0, 11'd1024, 11'd0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[r]) begin
      if (dir_rows[r].kind == RowCfg) begin
        set_count(dir_rows[r].cnt);
      end else begin
        send_req(dir_rows[r].op, dir_rows[r].entry, dir_rows[r].in_s, dir_rows[r].out_s,
                 dir_rows[r].typed, dir_rows[r].t_idx, dir_rows[r].t_oor);
      end
    end

    // Load every entry with ascending starts, some repeated, without gaps.
    set_count(11'd2047);
    calm = 1'b1;
    for (int e = 0; e < Depth; e++) begin
      fill_start = {e[9:0], 22'($urandom)};
      if (e > 0 && $urandom_range(0, 15) == 0) fill_start = in_starts[e-1];
      send_req(OpWrite, e[EntryW-1:0], fill_start, fill_start + 32'($urandom_range(0, 1 << 23)));
    end
    calm = 1'b0;

    foreach (phase_counts[p]) begin
      set_count((phase_counts[p] == 0 && p > 6) ? 11'($urandom_range(1, 2047))
                                                 : phase_counts[p]);
      if (p == 5) begin
        calm = 1'b1;
        run_mixed(PhaseItems, 35);
        calm = 1'b0;
      end else if (p == 10) begin
        // Keep lookups coming while the result side holds off, so the input stalls.
        calm     = 1'b1;
        hold_req = 1'b1;
        run_mixed(PhaseItems, 10);
        calm = 1'b0;
      end else if (p == 1) begin
        run_mixed(PhaseItems / 2, 35);
        drain();
        run_mixed(PhaseItems / 2, 35);
      end else begin
        run_mixed(PhaseItems, 35);
      end
    end

    drain();
    repeat (SettleWait) @(posedge clk_i);
    $display("Ran %0d table writes and %0d lookups (%0d out of range) over %0d count settings.",
             n_writes, n_lookups, n_oor, n_cfg);
    $display("Counts spanned zero, one, full depth and saturated values, with a long result hold-off.");
    if (err_cnt == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
